// ===== hw/rtl/cdll_pkg.sv =====
// Shared constants and codes for the circular doubly linked list block.
`default_nettype none

package cdll_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = DATA_W + 2 * SLOT_W;

  localparam logic [2:0] F_PUSH_FRONT = 3'd0;
  localparam logic [2:0] F_PUSH_BACK  = 3'd1;
  localparam logic [2:0] F_POP_FRONT  = 3'd2;
  localparam logic [2:0] F_POP_BACK   = 3'd3;
  localparam logic [2:0] F_INSERT     = 3'd4;
  localparam logic [2:0] F_REMOVE     = 3'd5;
  localparam logic [2:0] F_FIND       = 3'd6;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/cdll_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/circular_doubly_linked_list.sv =====
// Top level of the circular doubly linked list: sequencer around one slot memory.
`default_nettype none
// Usage:
// - Request channel: in_valid/in_stall with func, position and value. A beat is
//   taken when in_valid is high and in_stall is low. in_stall is high whenever
//   the sequencer is busy with a request.
// - Result channel: out_valid/out_stall with status, found, front_value,
//   back_value and count, held in an output register. One result beat per
//   request. A new request is taken while an earlier result still waits.
// - Each slot holds {value, next, prev} in one memory with a registered read.
//   Every link change is a read-modify-write of one slot.
// - Rejects, pops on a one-entry list and find on an empty list touch no
//   memory. Insert, remove and find walk the list one node per cycle. The
//   memory port serves one access per cycle.
// - Reset (rst, synchronous): empty list, all slots free, head and tail at
//   slot zero, no result pending. The slot memory is not cleared.
// - A stalled result holds; the sequencer then waits in its final state.

module circular_doubly_linked_list
  import cdll_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [4:0]  position,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             found,
  output logic [31:0]      front_value,
  output logic [31:0]      back_value,
  output logic [4:0]       count
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_WALKD = 4'd2;
  localparam logic [3:0] S_NEW   = 4'd3;
  localparam logic [3:0] S_PA_RD = 4'd4;
  localparam logic [3:0] S_PA_WR = 4'd5;
  localparam logic [3:0] S_PB_RD = 4'd6;
  localparam logic [3:0] S_PB_WR = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [1:0] MODE_LINK   = 2'd0;
  localparam logic [1:0] MODE_UNLINK = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  logic [3:0]          state;
  logic [1:0]          mode;
  logic [CAPACITY-1:0] free_map;
  logic [SLOT_W-1:0]   head;
  logic [SLOT_W-1:0]   tail;
  logic [CNT_W-1:0]    cnt;
  logic [DATA_W-1:0]   head_val;
  logic [DATA_W-1:0]   tail_val;

  logic [DATA_W-1:0]   req_value;
  logic [1:0]          res_status;
  logic                res_found;
  logic                link_front;
  logic                link_back;
  logic [SLOT_W-1:0]   new_slot;
  logic [SLOT_W-1:0]   cur;
  logic [SLOT_W-1:0]   steps;
  logic [SLOT_W-1:0]   p_slot;
  logic [SLOT_W-1:0]   n_slot;

  // Two pending link patches: slot, which field, new link.
  logic [SLOT_W-1:0]   pa_slot;
  logic                pa_next;
  logic [SLOT_W-1:0]   pa_link;
  logic [SLOT_W-1:0]   pb_slot;
  logic                pb_next;
  logic [SLOT_W-1:0]   pb_link;
  logic [DATA_W-1:0]   pa_val;
  logic [DATA_W-1:0]   pb_val;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [SLOT_W-1:0]   raddr;
  logic [ENTRY_W-1:0]  rdata;

  logic [DATA_W-1:0]   rd_value;
  logic [SLOT_W-1:0]   rd_next;
  logic [SLOT_W-1:0]   rd_prev;

  logic [SLOT_W-1:0]   free_slot;
  logic                full;
  logic                is_front;
  logic                is_back;

  function automatic logic [ENTRY_W-1:0] patch_entry(
    input logic [ENTRY_W-1:0] e,
    input logic               set_next,
    input logic [SLOT_W-1:0]  link
  );
    logic [ENTRY_W-1:0] r;
    r = e;
    if (set_next) begin
      r[2*SLOT_W-1:SLOT_W] = link;
    end else begin
      r[SLOT_W-1:0] = link;
    end
    return r;
  endfunction

  assign rd_value = rdata[ENTRY_W-1 -: DATA_W];
  assign rd_next  = rdata[2*SLOT_W-1:SLOT_W];
  assign rd_prev  = rdata[SLOT_W-1:0];

  assign in_stall = (state != S_IDLE);
  assign full     = (cnt == CNT_W'(CAPACITY));

  // Lowest-numbered free slot takes each new entry.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Which ends a new entry lands on; both when the list is empty.
  assign is_front = (func == F_PUSH_FRONT) || ((func == F_INSERT) && (position == 5'd0))
                    || (cnt == '0);
  assign is_back  = (func == F_PUSH_BACK) || ((func == F_INSERT) && (CNT_W'(position) == cnt))
                    || (cnt == '0);

  // Memory access per state: walk reads chain straight from the returned next link.
  always_comb begin
    we    = 1'b0;
    waddr = new_slot;
    wdata = {req_value, n_slot, p_slot};
    case (state)
      S_WALK:  raddr = cur;
      S_WALKD: raddr = rd_next;
      S_PA_RD: raddr = pa_slot;
      S_PB_RD: raddr = pb_slot;
      default: raddr = cur;
    endcase
    case (state)
      S_NEW: begin
        we = 1'b1;
      end
      S_PA_WR: begin
        we    = 1'b1;
        waddr = pa_slot;
        wdata = patch_entry(rdata, pa_next, pa_link);
      end
      S_PB_WR: begin
        we    = 1'b1;
        waddr = pb_slot;
        wdata = patch_entry(rdata, pb_next, pb_link);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  cdll_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_map  <= '1;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads this cycle.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_value <= value[DATA_W-1:0];
            res_found <= 1'b0;
            new_slot  <= free_slot;
            case (func)
              F_PUSH_FRONT, F_PUSH_BACK, F_INSERT: begin
                if ((func == F_INSERT) && (CNT_W'(position) > cnt)) begin
                  res_status <= ST_IGNORED;
                  state      <= S_DONE;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_DONE;
                  mode       <= MODE_LINK;
                  link_front <= is_front;
                  link_back  <= is_back;
                  if (cnt == '0) begin
                    p_slot <= free_slot;
                    n_slot <= free_slot;
                    state  <= S_NEW;
                  end else if (is_front || is_back) begin
                    // Link between tail and head.
                    cur   <= tail;
                    steps <= '0;
                    state <= S_WALK;
                  end else begin
                    cur   <= head;
                    steps <= SLOT_W'(position - 5'd1);
                    state <= S_WALK;
                  end
                end
              end
              F_POP_FRONT, F_POP_BACK, F_REMOVE: begin
                if ((func == F_REMOVE) &&
                    ((position == 5'd0) || (CNT_W'(position) > cnt))) begin
                  res_status <= ST_IGNORED;
                  state      <= S_DONE;
                end else if (cnt == '0) begin
                  res_status <= ST_IGNORED;
                  state      <= S_DONE;
                end else if (cnt == CNT_W'(1)) begin
                  // Last entry leaves: no link to fix.
                  res_status     <= ST_DONE;
                  free_map[head] <= 1'b1;
                  head           <= '0;
                  tail           <= '0;
                  cnt            <= '0;
                  state          <= S_DONE;
                end else begin
                  res_status <= ST_DONE;
                  mode       <= MODE_UNLINK;
                  cur        <= (func == F_POP_BACK) ? tail : head;
                  steps      <= (func == F_REMOVE) ? SLOT_W'(position - 5'd1) : '0;
                  state      <= S_WALK;
                end
              end
              F_FIND: begin
                res_status <= ST_DONE;
                if (cnt != '0) begin
                  mode  <= MODE_FIND;
                  cur   <= head;
                  steps <= SLOT_W'(cnt - CNT_W'(1));
                  state <= S_WALK;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          state <= S_WALKD;
        end
        S_WALKD: begin
          if (mode == MODE_FIND) begin
            if (rd_value == req_value) begin
              res_found <= 1'b1;
              state     <= S_DONE;
            end else if (steps == '0) begin
              state <= S_DONE;
            end else begin
              cur   <= rd_next;
              steps <= steps - SLOT_W'(1);
            end
          end else if (steps != '0) begin
            cur   <= rd_next;
            steps <= steps - SLOT_W'(1);
          end else if (mode == MODE_LINK) begin
            p_slot <= cur;
            n_slot <= rd_next;
            state  <= S_NEW;
          end else begin
            // Unlink cur: prev.next = next, next.prev = prev.
            p_slot  <= rd_prev;
            n_slot  <= rd_next;
            pa_slot <= rd_prev;
            pa_next <= 1'b1;
            pa_link <= rd_next;
            pb_slot <= rd_next;
            pb_next <= 1'b0;
            pb_link <= rd_prev;
            state   <= S_PA_RD;
          end
        end
        S_NEW: begin
          if (link_front && link_back) begin
            state <= S_FIN;
          end else begin
            pa_slot <= n_slot;
            pa_next <= 1'b0;
            pa_link <= new_slot;
            pb_slot <= p_slot;
            pb_next <= 1'b1;
            pb_link <= new_slot;
            state   <= S_PA_RD;
          end
        end
        S_PA_RD: begin
          state <= S_PA_WR;
        end
        S_PA_WR: begin
          pa_val <= rd_value;
          state  <= S_PB_RD;
        end
        S_PB_RD: begin
          state <= S_PB_WR;
        end
        S_PB_WR: begin
          pb_val <= rd_value;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (mode == MODE_LINK) begin
            free_map[new_slot] <= 1'b0;
            cnt                <= cnt + CNT_W'(1);
            if (link_front) begin
              head     <= new_slot;
              head_val <= req_value;
            end
            if (link_back) begin
              tail     <= new_slot;
              tail_val <= req_value;
            end
          end else begin
            free_map[cur] <= 1'b1;
            cnt           <= cnt - CNT_W'(1);
            if (cur == head) begin
              head     <= n_slot;
              head_val <= pb_val;
            end
            if (cur == tail) begin
              tail     <= p_slot;
              tail_val <= pa_val;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found       <= res_found;
            front_value <= (cnt != '0) ? 32'(head_val) : 32'd0;
            back_value  <= (cnt != '0) ? 32'(tail_val) : 32'd0;
            count       <= 5'(cnt);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
